>>> rtl/core/dpvs_pkg.sv
package dpvs_pkg;

   localparam int DECIMAL_DIGITS = 10;
   localparam int VALUE_W        = 30;
   localparam int COMP_W         = 30;
   localparam int BCD_W          = 4 * DECIMAL_DIGITS;
   localparam int BIT_CNT_W      = $clog2(VALUE_W);
   localparam int DIG_IDX_W      = (DECIMAL_DIGITS > 1) ? $clog2(DECIMAL_DIGITS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } dpvs_state_type;

   // handoff from the converter to the emitter
   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } dpvs_conv_type;

   typedef logic [COMP_W-1:0] pow_table_type [DECIMAL_DIGITS];

   function automatic pow_table_type pow10_table_f();
      pow_table_type   t;
      longint unsigned p;
      p = 1;
      for (int k = 0; k < DECIMAL_DIGITS; k++) begin
         t[k] = p[COMP_W-1:0];
         p    = p * 10;
      end
      return t;
   endfunction

   localparam pow_table_type POW10_TABLE = pow10_table_f();

endpackage

>>> rtl/core/decimal_place_value_splitter.sv
// Bit-serial binary-to-BCD shifting, MSB first, then a registered handoff, then
//   one decimal place scanned per cycle from the highest place down.
// One input at a time: busy stays high until the last item is out.
// A new start may be taken in the cycle the last item is on the rsp_ ports.
// Reset: synchronous, active high; clears both control FSMs, the handoff flag and the strobe.
// The receiver cannot stall: each item is on the rsp_ ports for exactly one cycle.
module decimal_place_value_splitter
   import dpvs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_strobe,
   output logic [COMP_W-1:0]   rsp_component,
   output logic                rsp_last
);

   dpvs_conv_type conv;
   logic          conv_busy;
   logic          emit_busy;

   // Converter: shifts the value in MSB first, adjusting BCD digits each step.
   dpvs_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .load  (start & ~busy),
      .value (req_value),
      .busy  (conv_busy),
      .conv  (conv)
   );

   // Emitter: walks digits from the highest place down, one per cycle,
   // scaling each nonzero digit by its power of ten.
   dpvs_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .conv          (conv),
      .busy          (emit_busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_component (rsp_component),
      .rsp_last      (rsp_last)
   );

   // One item in flight at a time.
   assign busy = conv_busy | emit_busy;

endmodule

>>> rtl/core/dpvs_dabble.sv
module dpvs_dabble
   import dpvs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [VALUE_W-1:0]  value,
   output logic                busy,
   output dpvs_conv_type       conv
);

   dpvs_state_type         state_ff, state_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic                   done_ff, done_in;

   // add-3 on every digit of 5 or more before each shift
   always_comb begin
      for (int d = 0; d < DECIMAL_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               bin_in   = value;
               bcd_in   = '0;
            end
         end
         ST_RUN: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy      = (state_ff != ST_IDLE) | done_ff;
   assign conv.done = done_ff;
   assign conv.bcd  = bcd_ff;

endmodule

>>> rtl/core/dpvs_emit.sv
module dpvs_emit
   import dpvs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dpvs_conv_type       conv,
   output logic                busy,
   output logic                rsp_strobe,
   output logic [COMP_W-1:0]   rsp_component,
   output logic                rsp_last
);

   dpvs_state_type          state_ff, state_in;
   logic [DIG_IDX_W-1:0]    idx_ff, idx_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic                    strobe_ff, strobe_in;
   logic [COMP_W-1:0]       comp_ff, comp_in;
   logic                    last_ff, last_in;
   logic [3:0]              top_digit;
   logic                    rest_zero;
   logic [COMP_W+3:0]       product;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   if (DECIMAL_DIGITS > 1) begin : g_rest
      assign rest_zero = (bcd_ff[BCD_W-5:0] == '0);
   end else begin : g_norest
      assign rest_zero = 1'b1;
   end
   assign product = top_digit * POW10_TABLE[idx_ff];

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      bcd_in    = bcd_ff;
      strobe_in = 1'b0;
      comp_in   = comp_ff;
      last_in   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (conv.done) begin
               if (conv.bcd == '0) begin
                  // nothing nonzero: one zero item, flagged last
                  strobe_in = 1'b1;
                  comp_in   = '0;
                  last_in   = 1'b1;
               end else begin
                  state_in = ST_RUN;
                  idx_in   = DIG_IDX_W'(DECIMAL_DIGITS - 1);
                  bcd_in   = conv.bcd;
               end
            end
         end
         ST_RUN: begin
            bcd_in = bcd_ff << 4;
            idx_in = idx_ff - 1'b1;
            if (top_digit != 4'd0) begin
               strobe_in = 1'b1;
               comp_in   = product[COMP_W-1:0];
               last_in   = rest_zero;
            end
            if ((idx_ff == '0) || ((top_digit != 4'd0) && rest_zero)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      idx_ff  <= idx_in;
      bcd_ff  <= bcd_in;
      comp_ff <= comp_in;
      last_ff <= last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_component = comp_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   a_zero_is_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (comp_ff == '0)) |-> last_ff)
      else $error("zero component without last");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |-> (state_ff == ST_IDLE))
      else $error("emitter still running after last item");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      conv.done |-> (state_ff == ST_IDLE))
      else $error("conversion finished while emitter busy");

   a_no_strobe_after_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> !strobe_ff)
      else $error("item emitted right after last");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb
   import dpvs_pkg::*;
();

   localparam longint unsigned VALUE_TOP = (64'd1 << VALUE_W) - 1;
   localparam int RANDOM_ITEMS = 130;
   localparam int STEADY_ITEMS = 30;     // tail of the run with no idling
   localparam int SETTLE_CYCLES = 60;    // longest first-result latency plus margin

   // one expected place value on the rsp_ side
   typedef struct packed {
      logic [COMP_W-1:0] component;
      logic              last;
   } place_part_type;

   // one item waiting to go out on the req_ side
   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 drain_first;   // hold until every expected part has arrived
      bit                 steady;        // no idle burst after this item
   } split_job_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [COMP_W-1:0]  rsp_component;
   logic               rsp_last;

   split_job_type  pending_jobs [$];
   place_part_type expected_parts [$];
   int             error_count = 0;

   // driver state
   int idle_left = 0;
   bit idle_any_cycle = 1'b0;   // burst counts every cycle, else only cycles the block is free
   bit job_steady = 1'b0;

   decimal_place_value_splitter u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_component (rsp_component),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected parts for one item: every nonzero digit times its power of ten,
   // highest place first; last marks the final part. A value with no nonzero
   // digit in the scanned places gives a single zero part with last set.
   function automatic void split_places(input logic [VALUE_W-1:0] value);
      longint unsigned rest;
      longint unsigned scale;
      longint unsigned place_amt [DECIMAL_DIGITS];
      place_part_type  parts [$];
      place_part_type  one;
      rest  = value;
      scale = 1;
      for (int k = 0; k < DECIMAL_DIGITS; k++) begin
         place_amt[k] = (rest % 10) * scale;
         rest         = rest / 10;
         scale        = scale * 10;
      end
      for (int k = DECIMAL_DIGITS - 1; k >= 0; k--) begin
         if (place_amt[k] != 0 && parts.size() < 10) begin
            one.component = COMP_W'(place_amt[k]);
            one.last      = 1'b0;
            parts         = {parts, one};
         end
      end
      if (parts.size() == 0) begin
         one.component = '0;
         one.last      = 1'b1;
         parts         = {parts, one};
      end else begin
         parts[parts.size() - 1].last = 1'b1;
      end
      foreach (parts[i]) expected_parts = {expected_parts, parts[i]};
   endfunction

   task automatic queue_job(input longint unsigned value, input bit drain_first,
                            input bit steady);
      split_job_type job;
      job.value       = VALUE_W'(value);
      job.drain_first = drain_first;
      job.steady      = steady;
      pending_jobs    = {pending_jobs, job};
   endtask

   // Driver. An item is taken at an edge where start is high and busy low.
   // start stays high from one item to the next unless an idle burst or a
   // drain hold comes between them, so back-to-back items land right as busy
   // drops, including the cycle the final part is on the rsp_ ports.
   always @(posedge clock) begin
      split_job_type job;
      bit            taken;
      taken = start && !busy;
      if (reset) begin
         start     <= 1'b0;
         idle_left  = 0;
      end else begin
         if (taken) begin
            split_places(req_value);
            if (!job_steady && $urandom_range(0, 2) == 0) begin
               idle_left      = $urandom_range(1, 16);
               idle_any_cycle = $urandom_range(0, 1);
            end
         end
         if (start && !taken) begin
            // item still waiting: leave start and req_value as they are
         end else if (idle_left > 0) begin
            if (idle_any_cycle || !busy) idle_left--;
            start <= 1'b0;
         end else if (pending_jobs.size() == 0) begin
            start <= 1'b0;
         end else if (pending_jobs[0].drain_first &&
                      (busy || expected_parts.size() != 0)) begin
            start <= 1'b0;
         end else begin
            job        = pending_jobs.pop_front();
            job_steady = job.steady;
            start     <= 1'b1;
            req_value <= job.value;
         end
      end
   end

   // Monitor: every strobe must match the oldest expected part, field by field.
   always @(posedge clock) begin
      place_part_type want;
      if (!reset && rsp_strobe) begin
         if (expected_parts.size() == 0) begin
            $error("unexpected part: component %0d last %0d", rsp_component, rsp_last);
            error_count++;
         end else begin
            want = expected_parts.pop_front();
            if (rsp_component !== want.component) begin
               $error("component: expected %0d, got %0d", want.component, rsp_component);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned     corner_values [$];
      longint unsigned pick;
      longint unsigned digit_val;
      bit              steady;
      bit              drain;
      corner_values = '{
         0, 1, 9, 10, 20, 99, 100, 505, 60000, 1000000, 101010101,
         123456789, 536870912, 900000009, 999999999, 1000000000,
         1000000001, 1010101010, 1073741822, 1073741823
      };

      // directed: zero, single digits, powers of ten, all-nonzero digits,
      // the largest component and the top of the input range
      foreach (corner_values[i]) queue_job(corner_values[i], 1'b0, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= RANDOM_ITEMS - STEADY_ITEMS);
         // first random item waits for a fully drained block; a few more at random
         drain = (n == 0) || (!steady && $urandom_range(0, 19) == 0);
         case ($urandom_range(0, 3))
            0: pick = longint'($urandom()) & VALUE_TOP;
            1: pick = $urandom_range(0, 999);
            2: begin
               // digit by digit, zeros about half the time
               pick = 0;
               for (int k = 0; k < DECIMAL_DIGITS; k++) begin
                  digit_val = $urandom_range(0, 1) ? $urandom_range(1, 9) : 0;
                  pick      = pick * 10 + digit_val;
               end
               if (pick > VALUE_TOP) pick = pick % 1000000000;
            end
            default: begin
               // one digit at one place
               pick = $urandom_range(1, 9);
               for (int k = $urandom_range(0, DECIMAL_DIGITS - 2); k > 0; k--)
                  pick = pick * 10;
            end
         endcase
         queue_job(pick, drain, steady);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() != 0 || start || busy || expected_parts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("** decimal_place_value_splitter: PASSED **");
      else
         $display("** decimal_place_value_splitter: FAILED **");
      $finish;
   end

   // Slowest honest run: ~150 items, each with up to 10 parts and an idle burst,
   // ends well inside this time limit.
   initial begin
      #2000000;
      $display("** decimal_place_value_splitter: FAILED **");
      $finish;
   end

endmodule
